// ===== design/fra_pkg.sv =====
// Shared constants, codes and helpers for the frame ring allocator.
// No dependencies; every other design file depends on this package.
package fra_pkg;

    localparam int DATA_W          = 32;
    localparam int STATUS_W        = 2;
    localparam int RETIRED_W       = 5;
    localparam int FRAME_DEPTH_DEF = 16;

    localparam logic [DATA_W-1:0]    RING_SIZE_RST = 32'd65536;
    localparam logic [DATA_W-1:0]    FRAME_CNT_RST = 32'd1;
    localparam logic [RETIRED_W-1:0] RETIRED_MAX   = 5'd31;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_END   = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_QFULL = 2'd2;

    // Unsigned add that saturates at all ones.
    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_W] ? '1 : s[DATA_W-1:0];
    endfunction

endpackage

// ===== design/fra_if.sv =====
// Valid/ready channel interfaces for the frame ring allocator.
// Depends on fra_pkg for field widths.
interface fra_in_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [fra_pkg::DATA_W-1:0] request_bytes;

    modport source (output valid, output command, output request_bytes, input ready);
    modport sink   (input valid, input command, input request_bytes, output ready);
endinterface

interface fra_out_if;
    logic                         valid;
    logic                         ready;
    logic [fra_pkg::DATA_W-1:0]    granted_offset;
    logic [fra_pkg::STATUS_W-1:0]  status;
    logic                         fence_signalled;
    logic [fra_pkg::DATA_W-1:0]    frame_number;
    logic [fra_pkg::RETIRED_W-1:0] frames_retired;

    modport source (output valid, output granted_offset, output status,
                    output fence_signalled, output frame_number, output frames_retired,
                    input ready);
    modport sink   (input valid, input granted_offset, input status,
                    input fence_signalled, input frame_number, input frames_retired,
                    output ready);
endinterface

// ===== design/frame_ring_allocator.sv =====
// Frame ring allocator: linear ring allocation with space freed one frame at a time.
//
// Channels: i_in carries commands (allocate with request_bytes, or end of frame),
// o_out returns exactly one result per command. A transfer happens when valid and
// ready are both high at a rising edge. i_cfg_wr_en / i_cfg_wr_data write ring_size
// and are meant to be used only while the block is idle.
// Flow: an allocate is accepted in S_IDLE and finished in S_CHECK, which it repeats
// for each old frame it retires, since the retire loop reads one frame start from the queue
// memory per cycle. An end of frame is answered straight from S_IDLE. The result sits in an output
// register; the block works on one command at a time and accepts the next one in
// the cycle its previous result is transferred or after the register empties.
// Reset (synchronous, active low) sets ring_size to 65536, empties the ring, sets
// the frame count to 1 and leaves one frame marker at offset 0. No clearing pass
// is needed; the block is ready right after reset.
// When the receiver stalls, the result is held and no new command is accepted.
module frame_ring_allocator #(
    parameter int FRAME_DEPTH = fra_pkg::FRAME_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [fra_pkg::DATA_W-1:0] i_cfg_wr_data,
    fra_in_if.sink                     i_in,
    fra_out_if.source                  o_out
);
    import fra_pkg::*;

    localparam int HW = $clog2(FRAME_DEPTH);
    localparam int FW = $clog2(FRAME_DEPTH + 1);
    localparam logic [HW-1:0] HEAD_LAST = HW'(FRAME_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(FRAME_DEPTH);
    localparam logic [FW-1:0] FILL_ONE  = FW'(1);
    localparam logic [HW:0]   DEPTH_EXT = (HW + 1)'(FRAME_DEPTH);

    typedef enum logic {S_IDLE, S_CHECK} t_state;

    function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] h);
        return (h == HEAD_LAST) ? '0 : h + 1'b1;
    endfunction

    // Control state.
    t_state              r_state, n_state;
    logic [DATA_W-1:0]   r_ring_size, n_ring_size;
    logic [DATA_W-1:0]   r_wr_ofs, n_wr_ofs;
    logic [DATA_W-1:0]   r_used, n_used;
    logic [DATA_W-1:0]   r_frame_cnt, n_frame_cnt;
    logic [HW-1:0]       r_head, n_head;
    logic [FW-1:0]       r_fill, n_fill;
    logic [DATA_W-1:0]   r_head_start, n_head_start;
    logic [DATA_W-1:0]   r_back_ofs, n_back_ofs;
    logic                r_out_valid, n_out_valid;

    // Payload registers.
    logic [DATA_W-1:0]    r_req, n_req;
    logic [RETIRED_W-1:0] r_retired, n_retired;
    logic [DATA_W-1:0]    r_out_granted, n_out_granted;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;
    logic                 r_out_fence, n_out_fence;
    logic [DATA_W-1:0]    r_out_fnum, n_out_fnum;
    logic [RETIRED_W-1:0] r_out_retired, n_out_retired;

    // Queue memory ports.
    logic              mem_wr_en;
    logic [HW-1:0]     mem_wr_addr;
    logic              mem_rd_en;
    logic [HW-1:0]     mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;

    logic              in_ready;
    logic              in_accept;
    logic [DATA_W:0]   wrap_sum;
    logic              do_wrap;
    logic [DATA_W-1:0] gap;
    logic [DATA_W-1:0] used_wrapped;
    logic              need_room;
    logic [DATA_W-1:0] tail;
    logic [DATA_W:0]   freed;
    logic [DATA_W-1:0] used_freed;
    logic [HW:0]       push_sum;
    logic [HW:0]       push_idx;

    fra_queue_mem #(
        .DEPTH  (FRAME_DEPTH),
        .ADDR_W (HW)
    ) u_queue_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (r_wr_ofs),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign in_ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_accept = i_in.valid && in_ready;

    // Wrap check on the incoming request, applied as the command is accepted.
    assign wrap_sum     = {1'b0, r_wr_ofs} + {1'b0, i_in.request_bytes};
    assign do_wrap      = {1'b0, r_ring_size} <= wrap_sum;
    assign gap          = (r_ring_size > r_wr_ofs) ? r_ring_size - r_wr_ofs : '0;
    assign used_wrapped = sat_add(r_used, gap);

    assign need_room = {1'b0, r_ring_size} < ({1'b0, r_used} + {1'b0, r_req});

    // Span of the oldest frame: from the cached head start to the next start.
    assign tail  = (r_ring_size > r_head_start) ? r_ring_size - r_head_start : '0;
    assign freed = (mem_rd_data < r_head_start) ? {1'b0, tail} + {1'b0, mem_rd_data}
                                                : {1'b0, mem_rd_data - r_head_start};
    assign used_freed = ({1'b0, r_used} > freed) ? r_used - freed[DATA_W-1:0] : '0;

    assign push_sum = {1'b0, r_head} + (HW + 1)'(r_fill);
    assign push_idx = (push_sum >= DEPTH_EXT) ? push_sum - DEPTH_EXT : push_sum;

    always_comb begin
        n_state       = r_state;
        n_ring_size   = r_ring_size;
        n_wr_ofs      = r_wr_ofs;
        n_used        = r_used;
        n_frame_cnt   = r_frame_cnt;
        n_head        = r_head;
        n_fill        = r_fill;
        n_head_start  = r_head_start;
        n_back_ofs    = r_back_ofs;
        n_out_valid   = r_out_valid;
        n_req         = r_req;
        n_retired     = r_retired;
        n_out_granted = r_out_granted;
        n_out_status  = r_out_status;
        n_out_fence   = r_out_fence;
        n_out_fnum    = r_out_fnum;
        n_out_retired = r_out_retired;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = push_idx[HW-1:0];
        mem_rd_en     = 1'b0;
        mem_rd_addr   = head_inc(r_head);

        if (i_cfg_wr_en) begin
            n_ring_size = i_cfg_wr_data;
        end
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // Prefetch the start of the second oldest frame for a retire.
                mem_rd_en = 1'b1;
                if (in_accept) begin
                    if (i_in.command == CMD_ALLOC) begin
                        n_req     = i_in.request_bytes;
                        n_retired = '0;
                        if (do_wrap) begin
                            n_wr_ofs = '0;
                            n_used   = used_wrapped;
                        end
                        n_state = S_CHECK;
                    end else begin
                        n_out_valid   = 1'b1;
                        n_out_granted = '0;
                        n_out_retired = '0;
                        n_out_fence   = 1'b0;
                        n_out_fnum    = r_frame_cnt;
                        n_out_status  = ST_OK;
                        if (r_back_ofs != r_wr_ofs) begin
                            if (r_fill >= FILL_FULL) begin
                                n_out_status = ST_QFULL;
                            end else begin
                                n_out_fence = 1'b1;
                                n_frame_cnt = r_frame_cnt + 1'b1;
                                mem_wr_en   = 1'b1;
                                n_back_ofs  = r_wr_ofs;
                                n_fill      = r_fill + 1'b1;
                            end
                        end
                    end
                end
            end
            S_CHECK: begin
                if (need_room && (r_fill > FILL_ONE)) begin
                    n_head       = head_inc(r_head);
                    n_fill       = r_fill - 1'b1;
                    n_head_start = mem_rd_data;
                    n_used       = used_freed;
                    n_retired    = (r_retired == RETIRED_MAX) ? r_retired
                                                              : r_retired + 1'b1;
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = head_inc(head_inc(r_head));
                end else begin
                    n_out_valid   = 1'b1;
                    n_out_fence   = 1'b0;
                    n_out_fnum    = r_frame_cnt;
                    n_out_retired = r_retired;
                    if (need_room) begin
                        n_out_status  = ST_OVER;
                        n_out_granted = '0;
                    end else begin
                        n_out_status  = ST_OK;
                        n_out_granted = r_wr_ofs;
                        n_wr_ofs      = sat_add(r_wr_ofs, r_req);
                        n_used        = sat_add(r_used, r_req);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ring_size   <= RING_SIZE_RST;
            r_wr_ofs      <= '0;
            r_used        <= '0;
            r_frame_cnt   <= FRAME_CNT_RST;
            r_head        <= '0;
            r_fill        <= FILL_ONE;
            r_head_start  <= '0;
            r_back_ofs    <= '0;
            r_out_valid   <= 1'b0;
            r_req         <= '0;
            r_retired     <= '0;
            r_out_granted <= '0;
            r_out_status  <= ST_OK;
            r_out_fence   <= 1'b0;
            r_out_fnum    <= '0;
            r_out_retired <= '0;
        end else begin
            r_state       <= n_state;
            r_ring_size   <= n_ring_size;
            r_wr_ofs      <= n_wr_ofs;
            r_used        <= n_used;
            r_frame_cnt   <= n_frame_cnt;
            r_head        <= n_head;
            r_fill        <= n_fill;
            r_head_start  <= n_head_start;
            r_back_ofs    <= n_back_ofs;
            r_out_valid   <= n_out_valid;
            r_req         <= n_req;
            r_retired     <= n_retired;
            r_out_granted <= n_out_granted;
            r_out_status  <= n_out_status;
            r_out_fence   <= n_out_fence;
            r_out_fnum    <= n_out_fnum;
            r_out_retired <= n_out_retired;
        end
    end

    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.granted_offset  = r_out_granted;
    assign o_out.status          = r_out_status;
    assign o_out.fence_signalled = r_out_fence;
    assign o_out.frame_number    = r_out_fnum;
    assign o_out.frames_retired  = r_out_retired;

endmodule

// ===== design/fra_queue_mem.sv =====
// Frame start offset memory: one write port, one read port, registered read data.
// Depends on fra_pkg for the data width.
module fra_queue_mem #(
    parameter int DEPTH  = fra_pkg::FRAME_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [fra_pkg::DATA_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [fra_pkg::DATA_W-1:0] o_rd_data
);
    import fra_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/fra_checker.sv =====
// Port-level assertions for the frame ring allocator, bound to the top level.
// Depends on fra_pkg for status codes and widths.
module fra_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [fra_pkg::DATA_W-1:0]    i_granted,
    input logic [fra_pkg::STATUS_W-1:0]  i_status,
    input logic                          i_fence,
    input logic [fra_pkg::RETIRED_W-1:0] i_retired
);
    import fra_pkg::*;

    // A signalled fence comes only from a clean end of frame.
    a_fence_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_fence |-> (i_status == ST_OK) && (i_granted == '0)
                                   && (i_retired == '0))
        else $error("fence signalled with a non-clean result");

    // A full frame queue is reported only by an end of frame.
    a_qfull_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_QFULL) |-> !i_fence && (i_granted == '0)
                                                 && (i_retired == '0))
        else $error("queue full status on a result that is not an end of frame");

    // A failed allocation grants no offset.
    a_over_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_OVER) |-> (i_granted == '0) && !i_fence)
        else $error("failed allocation returned an offset");

    // A stalled result stays put until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_granted)
                                       && $stable(i_status) && $stable(i_retired))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind frame_ring_allocator fra_checker u_fra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_granted   (o_out.granted_offset),
    .i_status    (o_out.status),
    .i_fence     (o_out.fence_signalled),
    .i_retired   (o_out.frames_retired)
);

// ===== bench/fra_result_checker.sv =====
// Result checker for the frame ring allocator: keeps its own copy of the ring and frame queue,
// predicts one result per command transfer and compares it with the output channel.
// Depends on fra_pkg and the channel interfaces fra_in_if / fra_out_if.
`timescale 1ns / 1ps

module fra_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [fra_pkg::DATA_W-1:0] i_cfg_wr_data,
    fra_in_if                          i_in,
    fra_out_if                         i_out,
    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_overflows,
    output int                         o_refused_ends,
    output int                         o_fences,
    output int                         o_frames_freed
);
    import fra_pkg::*;

    localparam int QDEPTH   = FRAME_DEPTH_DEF;
    localparam int SHOW_MAX = 10;

    typedef struct packed {
        logic [DATA_W-1:0]    offset;
        logic [STATUS_W-1:0]  status;
        logic                 fence;
        logic [DATA_W-1:0]    frame;
        logic [RETIRED_W-1:0] freed;
    } t_alloc_result;

    logic [DATA_W-1:0] ring_bytes;
    logic [DATA_W-1:0] wr_ptr;
    logic [DATA_W-1:0] bytes_in_use;
    logic [DATA_W-1:0] frame_ctr;
    logic [DATA_W-1:0] marker [QDEPTH];
    int                oldest;
    int                markers;

    t_alloc_result expected_q [$];

    int mismatches = 0, checked = 0, overflows = 0, refused = 0, fences = 0, freed_frames = 0;

    function automatic logic [DATA_W-1:0] clamp32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? '1 : v[DATA_W-1:0];
    endfunction

    function automatic t_alloc_result predict_result(input logic cmd,
                                                     input logic [DATA_W-1:0] req);
        t_alloc_result r;
        logic [63:0]   ring_w;
        logic [63:0]   req_w;
        logic [63:0]   start_old;
        logic [63:0]   start_next;
        logic [63:0]   span;
        bit            over;
        int            slot;
        r      = '0;
        ring_w = {32'd0, ring_bytes};
        req_w  = {32'd0, req};
        r.frame = frame_ctr;
        if (cmd == CMD_ALLOC) begin
            if (ring_w <= {32'd0, wr_ptr} + req_w) begin
                // The request would reach the end, so the tail is burned and we restart at zero.
                bytes_in_use = clamp32({32'd0, bytes_in_use} +
                    ((ring_w > {32'd0, wr_ptr}) ? ring_w - {32'd0, wr_ptr} : 64'd0));
                wr_ptr = '0;
            end
            over = ring_w < {32'd0, bytes_in_use} + req_w;
            while (over && markers > 1) begin
                start_old  = {32'd0, marker[oldest]};
                oldest     = (oldest + 1) % QDEPTH;
                markers    = markers - 1;
                start_next = {32'd0, marker[oldest]};
                if (start_next < start_old) begin
                    span = ((ring_w > start_old) ? ring_w - start_old : 64'd0) + start_next;
                end else begin
                    span = start_next - start_old;
                end
                bytes_in_use = ({32'd0, bytes_in_use} > span) ?
                               bytes_in_use - span[DATA_W-1:0] : '0;
                if (r.freed != RETIRED_MAX) r.freed = r.freed + 1'b1;
                over = ring_w < {32'd0, bytes_in_use} + req_w;
            end
            if (over) begin
                r.status = ST_OVER;
            end else begin
                r.offset     = wr_ptr;
                wr_ptr       = clamp32({32'd0, wr_ptr} + req_w);
                bytes_in_use = clamp32({32'd0, bytes_in_use} + req_w);
            end
        end else begin
            // A new marker is only needed when the write pointer moved since the newest one.
            slot = (oldest + markers - 1) % QDEPTH;
            if (marker[slot] != wr_ptr) begin
                if (markers >= QDEPTH) begin
                    r.status = ST_QFULL;
                end else begin
                    r.fence = 1'b1;
                    marker[(oldest + markers) % QDEPTH] = wr_ptr;
                    markers   = markers + 1;
                    frame_ctr = frame_ctr + 1'b1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        t_alloc_result want;
        t_alloc_result got;
        if (!i_rst_n) begin
            ring_bytes   = RING_SIZE_RST;
            wr_ptr       = '0;
            bytes_in_use = '0;
            frame_ctr    = FRAME_CNT_RST;
            foreach (marker[i]) marker[i] = '0;
            oldest  = 0;
            markers = 1;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) ring_bytes = i_cfg_wr_data;
            // A result in this transfer always belongs to an earlier command.
            if (i_out.valid && i_out.ready) begin
                got.offset = i_out.granted_offset;
                got.status = i_out.status;
                got.fence  = i_out.fence_signalled;
                got.frame  = i_out.frame_number;
                got.freed  = i_out.frames_retired;
                checked++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX) begin
                        $display("[%0t] result with no command outstanding: offset %0d status %0d",
                                 $time, got.offset, got.status);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (got.offset !== want.offset || got.status !== want.status ||
                        got.fence !== want.fence || got.frame !== want.frame ||
                        got.freed !== want.freed) begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX) begin
                            $display("[%0t] result mismatch (offset status fence frame freed)",
                                     $time);
                            $display("    expected %0d %0d %0d %0d %0d", want.offset,
                                     want.status, want.fence, want.frame, want.freed);
                            $display("    actual   %0d %0d %0d %0d %0d", got.offset,
                                     got.status, got.fence, got.frame, got.freed);
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                want = predict_result(i_in.command, i_in.request_bytes);
                expected_q.push_back(want);
                if (want.status == ST_OVER)  overflows++;
                if (want.status == ST_QFULL) refused++;
                if (want.fence)              fences++;
                freed_frames += want.freed;
            end
        end
        o_mismatches   <= mismatches;
        o_pending      <= expected_q.size();
        o_checked      <= checked;
        o_overflows    <= overflows;
        o_refused_ends <= refused;
        o_fences       <= fences;
        o_frames_freed <= freed_frames;
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the frame ring allocator bench: clock, reset, command and ring size stimulus,
// output back-pressure and the final verdict. Depends on fra_pkg, fra_if and fra_result_checker.
`timescale 1ns / 1ps

module tb_top;
    import fra_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 130;
    localparam int QDEPTH       = FRAME_DEPTH_DEF;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [DATA_W-1:0] i_cfg_wr_data = '0;

    fra_in_if  in_ch ();
    fra_out_if out_ch ();

    int mismatches, pending, checked, overflows, refused_ends, fences, frames_freed;

    int                cycles   = 0;
    int                n_items  = 0;
    int                n_rings  = 0;
    logic [DATA_W-1:0] cur_ring = RING_SIZE_RST;
    bit                no_idle  = 1'b0;
    bit                hold_req = 1'b0;
    bit                hold_done = 1'b0;

    frame_ring_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch.sink),
        .o_out         (out_ch.source)
    );

    fra_result_checker result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in           (in_ch),
        .i_out          (out_ch),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_overflows    (overflows),
        .o_refused_ends (refused_ends),
        .o_fences       (fences),
        .o_frames_freed (frames_freed)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly back-to-back, some short pauses and now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_request(input logic [DATA_W-1:0] ring);
        logic [DATA_W-1:0] scale;
        scale = (ring > 32'd8) ? ring / 8 : 32'd1;
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return $urandom();
            2:       return ring;
            3:       return ring + 32'd1;
            4:       return ring - 32'd1;
            5:       return $urandom_range(0, ring);
            6:       return '1;
            default: return $urandom_range(1, scale);
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [DATA_W-1:0] bytes);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.command       <= cmd;
        in_ch.request_bytes <= bytes;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_items++;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_ring(input logic [DATA_W-1:0] bytes);
        in_ch.valid <= 1'b0;
        wait_idle();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= bytes;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_ring = bytes;
        n_rings++;
    endtask

    // Receiver side: random ready pattern plus one long hold-off on request.
    initial begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [DATA_W-1:0] ring_plan [$];
        int                phase_end;
        int                n;
        ring_plan = '{32'd256, 32'd4096, 32'd65536, 32'd1, 32'd48, 32'hFFFF_FFFF,
                      32'd100000, 32'd0, 32'd1000, 32'd777};
        in_ch.valid         = 1'b0;
        in_ch.command       = CMD_ALLOC;
        in_ch.request_bytes = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty frame end, zero and huge requests, exact fit, wrap and retire.
        write_ring(32'd65536);
        send_item(CMD_END, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, 32'd100);
        send_item(CMD_END, '0);
        send_item(CMD_END, '1);
        send_item(CMD_ALLOC, 32'd65435);
        send_item(CMD_ALLOC, '1);
        send_item(CMD_END, '0);
        send_item(CMD_ALLOC, 32'd65536);
        // Shrinking the ring below the write pointer leaves no tail to burn.
        send_item(CMD_ALLOC, 32'd5000);
        send_item(CMD_END, '0);
        write_ring(32'd1000);
        send_item(CMD_ALLOC, 32'd10);
        // A zero-sized ring refuses everything but empty requests.
        write_ring(32'd0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, 32'd1);
        send_item(CMD_END, '0);
        write_ring(32'd1);
        send_item(CMD_ALLOC, 32'd1);
        send_item(CMD_ALLOC, 32'd1);
        send_item(CMD_END, '0);
        send_item(CMD_ALLOC, '0);
        // Largest ring: byte counters and the write pointer run into saturation.
        write_ring(32'hFFFF_FFFF);
        send_item(CMD_ALLOC, 32'hFFFF_FFFF);
        send_item(CMD_ALLOC, 32'h8000_0000);
        send_item(CMD_END, '0);
        send_item(CMD_ALLOC, 32'd1);

        // Random: frames of a few allocations, with bursts that fill the frame queue.
        foreach (ring_plan[p]) begin
            write_ring(ring_plan[p]);
            if (p == 1) hold_req <= 1'b1;
            no_idle   = (p == 3);
            phase_end = n_items + PHASE_ITEMS;
            while (n_items < phase_end) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat (QDEPTH + 2) begin
                        send_item(CMD_ALLOC, $urandom_range(1, 3));
                        send_item(CMD_END, $urandom());
                    end
                end else begin
                    n = $urandom_range(0, 5);
                    repeat (n) send_item(CMD_ALLOC, pick_request(cur_ring));
                    send_item(CMD_END, $urandom());
                    if ($urandom_range(0, 9) == 0) send_item(CMD_END, $urandom());
                end
            end
        end
        no_idle = 1'b0;

        in_ch.valid <= 1'b0;
        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d commands over %0d ring sizes and checked %0d results.",
                 n_items, n_rings, checked);
        $display("Refused allocations %0d, frames freed %0d, fences %0d, full-queue ends %0d.",
                 overflows, frames_freed, fences, refused_ends);
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/fra_pkg.sv
design/fra_if.sv
design/fra_queue_mem.sv
design/frame_ring_allocator.sv
design/fra_checker.sv
bench/fra_result_checker.sv
bench/tb_top.sv
